// ===== sv/frrd_pkg.sv =====
package frrd_pkg;

    // Command codes carried in s_axis_tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BIT   = 1'b1;

    // Decoder phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_METHOD = 3'd1;
    localparam logic [2:0] PH_ORDER  = 3'd2;
    localparam logic [2:0] PH_PARAM  = 3'd3;
    localparam logic [2:0] PH_ESCW   = 3'd4;
    localparam logic [2:0] PH_UNARY  = 3'd5;
    localparam logic [2:0] PH_LOW    = 3'd6;
    localparam logic [2:0] PH_RAW    = 3'd7;

    // Error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_METHOD   = 2'd1;
    localparam logic [1:0] ERR_ORDER    = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // Field lengths and escape codes of the stream header
    localparam logic [5:0] METHOD_LEN     = 6'd2;
    localparam logic [5:0] ORDER_LEN      = 6'd4;
    localparam logic [5:0] PARAM_LEN_STD  = 6'd4;
    localparam logic [5:0] PARAM_LEN_WIDE = 6'd5;
    localparam logic [5:0] ESCW_LEN       = 6'd5;
    localparam logic [4:0] ESC_CODE_STD   = 5'd15;
    localparam logic [4:0] ESC_CODE_WIDE  = 5'd31;

    // Fixed port field widths
    localparam int BLOCK_W    = 17;
    localparam int ORDER_W    = 6;
    localparam int RESID_W    = 32;
    localparam int RUN_W      = 17;
    localparam int SAMPLE_W   = 16;
    localparam int PART_W     = 15;
    localparam int PCOUNT_W   = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = 3;

    // One result item
    typedef struct packed {
        logic [RESID_W-1:0]  residual;
        logic [RUN_W-1:0]    run_length;
        logic [SAMPLE_W-1:0] sample_index;
        logic [PART_W-1:0]   partition_index;
        logic                escaped;
        logic                last;
        logic [1:0]          error_code;
    } result_t;

endpackage

// ===== sv/flac_residual_rice_decoder_core.sv =====
// Partitioned Rice residual decoder for one subframe, fed one stream bit per item.
// A start item (tuser = 0) latches block size and predictor order; each following
// bit item (tuser = 1) advances the decoder by one bit and yields at most one result
// item. Every input item is handled by the combinational bit-step logic that sits
// between the decoder state registers and the output register, so the block takes
// one item per clock unless stalled; a result appears on the master side in the cycle
// after the bit that completes it. s_axis_tready falls only while a result waits in the
// output register and m_axis_tready is low. There are no memories and no clearing pass.
module flac_residual_rice_decoder_core #(
    parameter int RESIDUAL_WIDTH  = 32,
    parameter int BLOCK_SIZE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // stream_bit [0], block_size [17:1], warmup_order [23:18]
    input  logic [frrd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // command [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // residual [31:0], run_length [48:32], sample_index [64:49],
    // partition_index [79:65]
    output logic [frrd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // escaped [0], error_code [2:1]
    output logic [frrd_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int BS_W        = BLOCK_SIZE_BITS + 1;
    localparam int RW_SH       = (RESIDUAL_WIDTH < 64) ? RESIDUAL_WIDTH : 63;
    localparam bit WIDTH_CHECK = (RESIDUAL_WIDTH < 64);
    localparam logic [frrd_pkg::BLOCK_W-1:0] BS_MAX = frrd_pkg::BLOCK_W'(1) << BLOCK_SIZE_BITS;

    // Input fields
    logic                              in_fire;
    logic                              in_bit;
    logic [frrd_pkg::BLOCK_W-1:0]      in_block_size;
    logic [frrd_pkg::ORDER_W-1:0]      in_order;

    // Decoder state
    logic [2:0]                        phase_reg, phase_next;
    logic                              wide_reg, wide_next;
    logic [3:0]                        porder_reg, porder_next;
    logic [frrd_pkg::PCOUNT_W-1:0]     pcount_reg, pcount_next;
    logic [BS_W-1:0]                   remaining_reg, remaining_next;
    logic [4:0]                        rice_k_reg, rice_k_next;
    logic [5:0]                        count_reg, count_next;
    logic [31:0]                       quot_reg, quot_next;
    logic [31:0]                       value_reg, value_next;
    logic [BS_W-1:0]                   done_reg, done_next;
    logic [BS_W-1:0]                   bs_reg, bs_next;
    logic [frrd_pkg::ORDER_W-1:0]      sorder_reg, sorder_next;

    // Output register
    logic                              out_valid_reg, out_valid_next;
    frrd_pkg::result_t                 out_reg, out_next;

    // Step logic
    frrd_pkg::result_t                 res;
    logic                              res_valid;
    logic [31:0]                       value_shift;
    logic [5:0]                        count_inc;
    logic [frrd_pkg::PCOUNT_W-1:0]     pcount_inc;
    logic [frrd_pkg::PCOUNT_W-1:0]     part_total;
    logic                              final_part;
    logic [31:0]                       quot_inc;
    logic [63:0]                       quot_inc_scaled;
    logic                              quot_too_wide;
    logic [63:0]                       rice_u;
    logic [31:0]                       rice_fold;
    logic                              rice_too_wide;
    logic [31:0]                       raw_mask;
    logic                              raw_sign;
    logic [31:0]                       raw_value;
    logic [BS_W-1:0]                   part_size;
    logic [5:0]                        param_len;
    logic [4:0]                        esc_code;
    logic                              do_emit;
    logic [31:0]                       emit_value;
    logic                              emit_esc;
    logic [2:0]                        emit_again;
    logic                              do_fail;
    logic [1:0]                        fail_code;
    logic                              do_finish;
    logic                              advance_part;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_bit        = s_axis_tdata[0];
    assign in_block_size = s_axis_tdata[17:1];
    assign in_order      = s_axis_tdata[23:18];
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    // Shared datapath terms
    assign value_shift     = {value_reg[30:0], in_bit};
    assign count_inc       = count_reg + 6'd1;
    assign pcount_inc      = pcount_reg + frrd_pkg::PCOUNT_W'(1);
    assign part_total      = frrd_pkg::PCOUNT_W'(1) << porder_reg;
    assign final_part      = pcount_inc >= part_total;
    assign quot_inc        = quot_reg + 32'd1;
    assign quot_inc_scaled = 64'(quot_inc) << rice_k_reg;
    assign quot_too_wide   = WIDTH_CHECK && ((quot_inc_scaled >> RW_SH) != 64'd0);
    assign param_len       = wide_reg ? frrd_pkg::PARAM_LEN_WIDE : frrd_pkg::PARAM_LEN_STD;
    assign esc_code        = wide_reg ? frrd_pkg::ESC_CODE_WIDE : frrd_pkg::ESC_CODE_STD;

    // Rice value: quotient scaled by k, low bits ORed in while in the low-bit phase
    always_comb
    begin
        rice_u = 64'(quot_reg) << rice_k_reg;
        if (phase_reg == frrd_pkg::PH_LOW)
        begin
            rice_u = rice_u | 64'(value_shift);
        end
    end
    assign rice_too_wide = WIDTH_CHECK && ((rice_u >> RW_SH) != 64'd0);
    assign rice_fold     = rice_u[0] ? ~rice_u[32:1] : rice_u[32:1];

    // Raw escape sample: sign-extend from the escape width
    assign raw_mask  = 32'hFFFF_FFFF << rice_k_reg;
    assign raw_sign  = value_shift[5'(rice_k_reg - 5'd1)];
    assign raw_value = raw_sign ? (value_shift | raw_mask) : (value_shift & ~raw_mask);

    // Partition size: first partition loses the warm-up samples
    always_comb
    begin
        part_size = bs_reg >> porder_reg;
        if (pcount_reg == '0)
        begin
            part_size = part_size - BS_W'(sorder_reg);
        end
    end

    // Advance the decoder by one item
    always_comb
    begin
        phase_next     = phase_reg;
        wide_next      = wide_reg;
        porder_next    = porder_reg;
        pcount_next    = pcount_reg;
        remaining_next = remaining_reg;
        rice_k_next    = rice_k_reg;
        count_next     = count_reg;
        quot_next      = quot_reg;
        value_next     = value_reg;
        done_next      = done_reg;
        bs_next        = bs_reg;
        sorder_next    = sorder_reg;

        res_valid           = 1'b0;
        res.residual        = '0;
        res.run_length      = '0;
        res.sample_index    = frrd_pkg::SAMPLE_W'(done_reg);
        res.partition_index = frrd_pkg::PART_W'(pcount_reg);
        res.escaped         = 1'b0;
        res.last            = 1'b0;
        res.error_code      = frrd_pkg::ERR_OK;

        do_emit      = 1'b0;
        emit_value   = '0;
        emit_esc     = 1'b0;
        emit_again   = frrd_pkg::PH_UNARY;
        do_fail      = 1'b0;
        fail_code    = frrd_pkg::ERR_OK;
        do_finish    = 1'b0;
        advance_part = 1'b0;

        if (in_fire)
        begin
            if (s_axis_tuser == frrd_pkg::CMD_START)
            begin
                // Abandon any section and latch the new block
                wide_next      = 1'b0;
                porder_next    = '0;
                pcount_next    = '0;
                remaining_next = '0;
                rice_k_next    = '0;
                count_next     = '0;
                quot_next      = '0;
                value_next     = '0;
                done_next      = '0;
                bs_next        = (in_block_size > BS_MAX) ? BS_W'(BS_MAX) : BS_W'(in_block_size);
                sorder_next    = in_order;
                phase_next     = frrd_pkg::PH_METHOD;
            end
            else
            begin
                case (phase_reg)
                    frrd_pkg::PH_METHOD:
                    begin
                        value_next = value_shift;
                        count_next = count_inc;
                        if (count_inc >= frrd_pkg::METHOD_LEN)
                        begin
                            if (value_shift[1])
                            begin
                                do_fail   = 1'b1;
                                fail_code = frrd_pkg::ERR_METHOD;
                            end
                            else
                            begin
                                wide_next  = value_shift[0];
                                count_next = '0;
                                value_next = '0;
                                phase_next = frrd_pkg::PH_ORDER;
                            end
                        end
                    end
                    frrd_pkg::PH_ORDER:
                    begin
                        value_next = value_shift;
                        count_next = count_inc;
                        if (count_inc >= frrd_pkg::ORDER_LEN)
                        begin
                            porder_next = value_shift[3:0];
                            if ((bs_reg >> value_shift[3:0]) < BS_W'(sorder_reg))
                            begin
                                do_fail   = 1'b1;
                                fail_code = frrd_pkg::ERR_ORDER;
                            end
                            else
                            begin
                                pcount_next = '0;
                                count_next  = '0;
                                value_next  = '0;
                                phase_next  = frrd_pkg::PH_PARAM;
                            end
                        end
                    end
                    frrd_pkg::PH_PARAM:
                    begin
                        value_next = value_shift;
                        count_next = count_inc;
                        if (count_inc >= param_len)
                        begin
                            remaining_next = part_size;
                            rice_k_next    = value_shift[4:0];
                            count_next     = '0;
                            value_next     = '0;
                            quot_next      = '0;
                            if (value_shift[4:0] == esc_code)
                            begin
                                phase_next = frrd_pkg::PH_ESCW;
                            end
                            else if (part_size == '0)
                            begin
                                advance_part = 1'b1;
                            end
                            else
                            begin
                                phase_next = frrd_pkg::PH_UNARY;
                            end
                        end
                    end
                    frrd_pkg::PH_ESCW:
                    begin
                        value_next = value_shift;
                        count_next = count_inc;
                        if (count_inc >= frrd_pkg::ESCW_LEN)
                        begin
                            rice_k_next = value_shift[4:0];
                            count_next  = '0;
                            value_next  = '0;
                            if (remaining_reg == '0)
                            begin
                                advance_part = 1'b1;
                            end
                            else if (value_shift[4:0] == 5'd0)
                            begin
                                // Zero-width escape: one run covering the partition
                                res_valid      = 1'b1;
                                res.run_length = frrd_pkg::RUN_W'(remaining_reg);
                                res.escaped    = 1'b1;
                                res.last       = final_part;
                                done_next      = done_reg + remaining_reg;
                                remaining_next = '0;
                                advance_part   = 1'b1;
                            end
                            else
                            begin
                                phase_next = frrd_pkg::PH_RAW;
                            end
                        end
                    end
                    frrd_pkg::PH_UNARY:
                    begin
                        if (!in_bit)
                        begin
                            if ((quot_reg == 32'hFFFF_FFFF) || quot_too_wide)
                            begin
                                do_fail   = 1'b1;
                                fail_code = frrd_pkg::ERR_OVERFLOW;
                            end
                            else
                            begin
                                quot_next = quot_inc;
                            end
                        end
                        else
                        begin
                            value_next = '0;
                            count_next = '0;
                            if (rice_k_reg == 5'd0)
                            begin
                                do_finish = 1'b1;
                            end
                            else
                            begin
                                phase_next = frrd_pkg::PH_LOW;
                            end
                        end
                    end
                    frrd_pkg::PH_LOW:
                    begin
                        value_next = value_shift;
                        count_next = count_inc;
                        if (count_inc >= {1'b0, rice_k_reg})
                        begin
                            do_finish = 1'b1;
                        end
                    end
                    frrd_pkg::PH_RAW:
                    begin
                        value_next = value_shift;
                        count_next = count_inc;
                        if (count_inc >= {1'b0, rice_k_reg})
                        begin
                            do_emit    = 1'b1;
                            emit_value = raw_value;
                            emit_esc   = 1'b1;
                            emit_again = frrd_pkg::PH_RAW;
                        end
                    end
                    default:
                    begin
                        // Idle: drop stray bits
                    end
                endcase
            end
        end

        // Close a Rice code: range check, then fold to signed
        if (do_finish)
        begin
            if (rice_too_wide)
            begin
                do_fail   = 1'b1;
                fail_code = frrd_pkg::ERR_OVERFLOW;
            end
            else
            begin
                do_emit    = 1'b1;
                emit_value = rice_fold;
                emit_esc   = 1'b0;
                emit_again = frrd_pkg::PH_UNARY;
            end
        end

        // Emit one single-sample item
        if (do_emit)
        begin
            res_valid      = 1'b1;
            res.residual   = emit_value;
            res.run_length = frrd_pkg::RUN_W'(1);
            res.escaped    = emit_esc;
            res.last       = (remaining_reg == BS_W'(1)) && final_part;
            done_next      = done_reg + BS_W'(1);
            remaining_next = remaining_reg - BS_W'(1);
            count_next     = '0;
            value_next     = '0;
            quot_next      = '0;
            if (remaining_reg == BS_W'(1))
            begin
                advance_part = 1'b1;
            end
            else
            begin
                phase_next = emit_again;
            end
        end

        // Move to the next partition or end the section
        if (advance_part)
        begin
            pcount_next = pcount_inc;
            if (final_part)
            begin
                phase_next = frrd_pkg::PH_IDLE;
            end
            else
            begin
                phase_next = frrd_pkg::PH_PARAM;
                count_next = '0;
                value_next = '0;
            end
        end

        // Error item ends the section
        if (do_fail)
        begin
            res_valid      = 1'b1;
            res.residual   = '0;
            res.run_length = '0;
            res.escaped    = 1'b0;
            res.last       = 1'b1;
            res.error_code = fail_code;
            phase_next     = frrd_pkg::PH_IDLE;
        end
    end

    // Load the output register, hold it while stalled
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (in_fire && res_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= frrd_pkg::PH_IDLE;
            wide_reg      <= 1'b0;
            porder_reg    <= '0;
            pcount_reg    <= '0;
            remaining_reg <= '0;
            rice_k_reg    <= '0;
            count_reg     <= '0;
            quot_reg      <= '0;
            value_reg     <= '0;
            done_reg      <= '0;
            bs_reg        <= '0;
            sorder_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            wide_reg      <= wide_next;
            porder_reg    <= porder_next;
            pcount_reg    <= pcount_next;
            remaining_reg <= remaining_next;
            rice_k_reg    <= rice_k_next;
            count_reg     <= count_next;
            quot_reg      <= quot_next;
            value_reg     <= value_next;
            done_reg      <= done_next;
            bs_reg        <= bs_next;
            sorder_reg    <= sorder_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.partition_index, out_reg.sample_index,
                            out_reg.run_length, out_reg.residual};
    assign m_axis_tuser  = {out_reg.error_code, out_reg.escaped};
    assign m_axis_tlast  = out_reg.last;

    // An error item always closes the section
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] != frrd_pkg::ERR_OK)) |-> m_axis_tlast)
        else $error("error item without tlast");

    // An error item carries no run
    a_error_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] != frrd_pkg::ERR_OK)) |->
        (m_axis_tdata[48:32] == '0))
        else $error("error item with nonzero run length");

    // The decoder goes idle after an error
    a_error_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && res_valid && (res.error_code != frrd_pkg::ERR_OK)) |=>
        (phase_reg == frrd_pkg::PH_IDLE))
        else $error("decoder not idle after error");

    // A start item rewinds the section
    a_start_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_axis_tuser == frrd_pkg::CMD_START)) |=>
        ((phase_reg == frrd_pkg::PH_METHOD) && (done_reg == '0) && (pcount_reg == '0)))
        else $error("start item did not rewind the decoder");

endmodule

// ===== bench/tb_flac_residual_rice_decoder_core.sv =====
module tb_flac_residual_rice_decoder_core;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned DRAIN_LIMIT   = 5000;
    localparam int unsigned RANDOM_ITEMS  = 1950;
    localparam int unsigned MAX_BLOCK     = 32'd1 << 16;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // stream_bit [0], block_size [17:1], warmup_order [23:18]
    logic [frrd_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // command [0]
    logic                            s_axis_tuser = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // residual [31:0], run_length [48:32], sample_index [64:49],
    // partition_index [79:65]
    logic [frrd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    // escaped [0], error_code [2:1]
    logic [frrd_pkg::OUT_USER_W-1:0] m_axis_tuser;
    logic                            m_axis_tlast;

    // Stimulus and checking state
    logic              bit_stream[$];
    frrd_pkg::result_t pending_residuals[$];
    int unsigned       fail_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       bit_items = 0;
    int unsigned       stall_left = 0;
    bit                tx_gaps = 1'b1;
    bit                rx_gaps = 1'b1;

    // Decoder state mirrored by the predictor
    logic [2:0]  dec_phase;
    int unsigned dec_wide, dec_porder, dec_part, dec_left, dec_k;
    int unsigned dec_nbits, dec_quot, dec_acc, dec_done, dec_blk, dec_pord;

    flac_residual_rice_decoder_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic reset_decoder();
        dec_phase  = frrd_pkg::PH_IDLE;
        dec_wide   = 0;
        dec_porder = 0;
        dec_part   = 0;
        dec_left   = 0;
        dec_k      = 0;
        dec_nbits  = 0;
        dec_quot   = 0;
        dec_acc    = 0;
        dec_done   = 0;
        dec_blk    = 0;
        dec_pord   = 0;
    endtask

    task automatic record_result(input logic [31:0] res, input int unsigned run,
                                 input logic esc, input logic fin, input logic [1:0] err);
        frrd_pkg::result_t r;
        r.residual        = res;
        r.run_length      = run[frrd_pkg::RUN_W-1:0];
        r.sample_index    = dec_done[frrd_pkg::SAMPLE_W-1:0];
        r.partition_index = dec_part[frrd_pkg::PART_W-1:0];
        r.escaped         = esc;
        r.last            = fin;
        r.error_code      = err;
        pending_residuals.push_back(r);
    endtask

    // Report the error at the position reached and drop the section
    task automatic abort_section(input logic [1:0] err);
        record_result(32'd0, 0, 1'b0, 1'b1, err);
        dec_phase = frrd_pkg::PH_IDLE;
    endtask

    function automatic bit on_last_partition();
        return dec_part + 1 >= (32'd1 << dec_porder);
    endfunction

    task automatic next_partition();
        dec_part = (dec_part + 1) & 32'hFFFF;
        if (dec_part >= (32'd1 << dec_porder))
        begin
            dec_phase = frrd_pkg::PH_IDLE;
        end
        else
        begin
            dec_phase = frrd_pkg::PH_PARAM;
            dec_nbits = 0;
            dec_acc   = 0;
        end
    endtask

    task automatic emit_sample(input logic [31:0] value, input logic esc,
                               input logic [2:0] again);
        logic fin;
        fin = (dec_left == 1) && on_last_partition();
        record_result(value, 1, esc, fin, frrd_pkg::ERR_OK);
        dec_done  = (dec_done + 1) & 32'h1FFFF;
        dec_left  = dec_left - 1;
        dec_nbits = 0;
        dec_acc   = 0;
        dec_quot  = 0;
        if (dec_left == 0)
            next_partition();
        else
            dec_phase = again;
    endtask

    // Join quotient and low bits, then fold to a signed residual
    task automatic finish_rice();
        longint unsigned u;
        logic [31:0]     s;
        u = dec_quot;
        u = (u << dec_k) | dec_acc;
        if ((u >> frrd_pkg::RESID_W) != 0)
        begin
            abort_section(frrd_pkg::ERR_OVERFLOW);
        end
        else
        begin
            s = u[0] ? ~u[32:1] : u[32:1];
            emit_sample(s, 1'b0, frrd_pkg::PH_UNARY);
        end
    endtask

    task automatic decode_stream_item(input logic cmd, input logic b,
                                      input logic [16:0] bs, input logic [5:0] po);
        int unsigned     part, w;
        longint unsigned q;
        logic [31:0]     v;
        if (cmd == frrd_pkg::CMD_START)
        begin
            part = bs;
            if (part > MAX_BLOCK)
                part = MAX_BLOCK;
            reset_decoder();
            dec_blk   = part;
            dec_pord  = po;
            dec_phase = frrd_pkg::PH_METHOD;
        end
        else
        begin
            case (dec_phase)
                frrd_pkg::PH_METHOD:
                begin
                    dec_acc   = ((dec_acc << 1) | b) & 3;
                    dec_nbits = dec_nbits + 1;
                    if (dec_nbits == frrd_pkg::METHOD_LEN)
                    begin
                        if (dec_acc > 1)
                        begin
                            abort_section(frrd_pkg::ERR_METHOD);
                        end
                        else
                        begin
                            dec_wide  = dec_acc;
                            dec_nbits = 0;
                            dec_acc   = 0;
                            dec_phase = frrd_pkg::PH_ORDER;
                        end
                    end
                end
                frrd_pkg::PH_ORDER:
                begin
                    dec_acc   = ((dec_acc << 1) | b) & 15;
                    dec_nbits = dec_nbits + 1;
                    if (dec_nbits == frrd_pkg::ORDER_LEN)
                    begin
                        dec_porder = dec_acc;
                        if ((dec_blk >> dec_porder) < dec_pord)
                        begin
                            abort_section(frrd_pkg::ERR_ORDER);
                        end
                        else
                        begin
                            dec_part  = 0;
                            dec_nbits = 0;
                            dec_acc   = 0;
                            dec_phase = frrd_pkg::PH_PARAM;
                        end
                    end
                end
                frrd_pkg::PH_PARAM:
                begin
                    dec_acc   = ((dec_acc << 1) | b) & 31;
                    dec_nbits = dec_nbits + 1;
                    if (dec_nbits == (dec_wide != 0 ? frrd_pkg::PARAM_LEN_WIDE
                                                    : frrd_pkg::PARAM_LEN_STD))
                    begin
                        part = dec_blk >> dec_porder;
                        if (dec_part == 0)
                            part = part - dec_pord;
                        dec_left  = part;
                        dec_k     = dec_acc;
                        dec_nbits = 0;
                        dec_acc   = 0;
                        dec_quot  = 0;
                        if (dec_k == (dec_wide != 0 ? frrd_pkg::ESC_CODE_WIDE
                                                    : frrd_pkg::ESC_CODE_STD))
                            dec_phase = frrd_pkg::PH_ESCW;
                        else if (dec_left == 0)
                            next_partition();
                        else
                            dec_phase = frrd_pkg::PH_UNARY;
                    end
                end
                frrd_pkg::PH_ESCW:
                begin
                    dec_acc   = ((dec_acc << 1) | b) & 31;
                    dec_nbits = dec_nbits + 1;
                    if (dec_nbits == frrd_pkg::ESCW_LEN)
                    begin
                        dec_k     = dec_acc;
                        dec_nbits = 0;
                        dec_acc   = 0;
                        if (dec_left == 0)
                        begin
                            next_partition();
                        end
                        else if (dec_k == 0)
                        begin
                            // Zero width: the whole partition is one run of zeros
                            record_result(32'd0, dec_left, 1'b1, on_last_partition(),
                                          frrd_pkg::ERR_OK);
                            dec_done = (dec_done + dec_left) & 32'h1FFFF;
                            dec_left = 0;
                            next_partition();
                        end
                        else
                        begin
                            dec_phase = frrd_pkg::PH_RAW;
                        end
                    end
                end
                frrd_pkg::PH_UNARY:
                begin
                    if (b == 1'b0)
                    begin
                        if (dec_quot == 32'hFFFF_FFFF)
                        begin
                            abort_section(frrd_pkg::ERR_OVERFLOW);
                        end
                        else
                        begin
                            dec_quot = dec_quot + 1;
                            q = dec_quot;
                            if (((q << dec_k) >> frrd_pkg::RESID_W) != 0)
                                abort_section(frrd_pkg::ERR_OVERFLOW);
                        end
                    end
                    else
                    begin
                        dec_acc   = 0;
                        dec_nbits = 0;
                        if (dec_k == 0)
                            finish_rice();
                        else
                            dec_phase = frrd_pkg::PH_LOW;
                    end
                end
                frrd_pkg::PH_LOW:
                begin
                    dec_acc   = (dec_acc << 1) | b;
                    dec_nbits = dec_nbits + 1;
                    if (dec_nbits >= dec_k)
                        finish_rice();
                end
                frrd_pkg::PH_RAW:
                begin
                    w         = dec_k & 31;
                    dec_acc   = (dec_acc << 1) | b;
                    dec_nbits = dec_nbits + 1;
                    if (dec_nbits >= w)
                    begin
                        v = dec_acc;
                        // Sign-extend the raw w-bit sample
                        if (w > 0 && w < 32)
                        begin
                            v = v & ((32'd1 << w) - 1);
                            if (v[w-1])
                                v = v | (~32'd0 << w);
                        end
                        emit_sample(v, 1'b1, frrd_pkg::PH_RAW);
                    end
                end
                default:
                begin
                    // Idle: the bit is ignored
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic string fmt_result(input frrd_pkg::result_t r);
        return $sformatf("res=%h run=%0d smp=%0d part=%0d esc=%b last=%b err=%0d",
                         r.residual, r.run_length, r.sample_index, r.partition_index,
                         r.escaped, r.last, r.error_code);
    endfunction

    // Predict on each accepted item, then compare each accepted result
    always @(posedge clk)
    begin : check_residuals
        frrd_pkg::result_t got;
        frrd_pkg::result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                decode_stream_item(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[17:1],
                                   s_axis_tdata[23:18]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.residual        = m_axis_tdata[31:0];
                got.run_length      = m_axis_tdata[48:32];
                got.sample_index    = m_axis_tdata[64:49];
                got.partition_index = m_axis_tdata[79:65];
                got.escaped         = m_axis_tuser[0];
                got.last            = m_axis_tlast;
                got.error_code      = m_axis_tuser[2:1];
                if (pending_residuals.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: %s", fmt_result(got));
                    fail_count++;
                end
                else
                begin
                    want = pending_residuals.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %s, got %s",
                                     fmt_result(want), fmt_result(got));
                        fail_count++;
                    end
                end
            end
        end
    end

    // Hold off the result side in random bursts
    always @(posedge clk)
    begin
        if (rx_gaps && stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_gaps && $urandom_range(0, 11) == 0)
        begin
            stall_left    <= $urandom_range(0, 16);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic send_item(input logic cmd, input logic b, input logic [16:0] bs,
                             input logic [5:0] po);
        if (tx_gaps && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {po, bs, b};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic start_section(input logic [16:0] bs, input logic [5:0] po);
        send_item(frrd_pkg::CMD_START, 1'($urandom_range(0, 1)), bs, po);
    endtask

    // Append a field, most significant bit first
    task automatic put_field(input logic [31:0] value, input int len);
        for (int i = len - 1; i >= 0; i--)
            bit_stream.push_back(value[i]);
    endtask

    task automatic send_stream();
        while (bit_stream.size() != 0)
        begin
            send_item(frrd_pkg::CMD_BIT, bit_stream.pop_front(), 17'($urandom),
                      6'($urandom));
            bit_items++;
        end
    endtask

    // Pause the sender until every predicted result has come out or the drain limit is hit
    task automatic wait_for_results();
        int unsigned waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_residuals.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    // Build a section body with random content; a method above 1 or a short partition makes it malformed
    task automatic build_section(input int unsigned bs, input int unsigned po,
                                 input logic [1:0] method, input logic [3:0] porder,
                                 input bit flat);
        int unsigned eff, part, size, plen, kmax, k, w, q, qlim, sel;
        logic [31:0] low;
        eff = (bs > MAX_BLOCK) ? MAX_BLOCK : bs;
        put_field(method, frrd_pkg::METHOD_LEN);
        if (method > 1)
        begin
            put_field($urandom, frrd_pkg::ORDER_LEN);
            return;
        end
        put_field(porder, frrd_pkg::ORDER_LEN);
        part = eff >> porder;
        if (part < po)
            return;
        plen = method[0] ? frrd_pkg::PARAM_LEN_WIDE : frrd_pkg::PARAM_LEN_STD;
        kmax = method[0] ? 30 : 14;
        for (int p = 0; p < (1 << porder); p++)
        begin
            size = (p == 0) ? part - po : part;
            if (flat || $urandom_range(0, 4) == 0)
            begin
                put_field(method[0] ? frrd_pkg::ESC_CODE_WIDE : frrd_pkg::ESC_CODE_STD, plen);
                sel = $urandom_range(0, 9);
                if (flat || sel == 0)
                    w = 0;
                else if (sel == 1)
                    w = $urandom_range(9, 31);
                else
                    w = $urandom_range(1, 8);
                put_field(w, frrd_pkg::ESCW_LEN);
                if (w != 0)
                    for (int s = 0; s < size; s++)
                        put_field($urandom, w);
            end
            else
            begin
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, kmax)
                                                : $urandom_range(0, 4);
                put_field(k, plen);
                for (int s = 0; s < size; s++)
                begin
                    // Large k lets the quotient hit the overflow edge
                    qlim = (k >= 28) ? (32'd1 << (32 - k)) : 6;
                    q    = $urandom_range(0, qlim);
                    repeat (q) bit_stream.push_back(1'b0);
                    bit_stream.push_back(1'b1);
                    low = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
                    put_field(low, k);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_header_errors();
        // Bits before any start are ignored
        put_field(2'b10, 2);
        send_stream();
        start_section(17'd7, 6'd1);
        put_field(2'b10, frrd_pkg::METHOD_LEN);
        send_stream();
        start_section(17'd7, 6'd1);
        put_field(2'b11, frrd_pkg::METHOD_LEN);
        send_stream();
        // Oversized block, highest order: order mismatch
        start_section(17'h1FFFF, 6'd32);
        put_field(6'b00_1111, 6);
        send_stream();
        wait_for_results();
    endtask

    task automatic test_empty_partitions();
        // Empty block, then idle bits after the silent end
        start_section(17'd0, 6'd0);
        put_field(11'b01_0000_00000, 11);
        put_field(2'b11, 2);
        send_stream();
        // Largest block as one zero-width escape run
        start_section(17'd65536, 6'd0);
        put_field(15'b00_0000_1111_00000, 15);
        send_stream();
        wait_for_results();
    endtask

    task automatic test_rice_extremes();
        // One zero-parameter code, then abandon the section with a restart
        start_section(17'd4, 6'd0);
        put_field(11'b00_0001_0000_1, 11);
        send_stream();
        // k = 30: most negative, most positive, then quotient overflow
        start_section(17'd3, 6'd0);
        put_field(11'b01_0000_11110, 11);
        put_field(4'b0001, 4);
        put_field(32'h3FFF_FFFF, 30);
        put_field(4'b0001, 4);
        put_field(32'h3FFF_FFFE, 30);
        put_field(4'b0000, 4);
        send_stream();
        wait_for_results();
    endtask

    task automatic test_random_sections();
        int unsigned bs, po, part, idx;
        logic [1:0]  method;
        logic [3:0]  porder;
        bit          flat;
        while (bit_items < RANDOM_ITEMS)
        begin
            // Quiet tail: no idling at all
            if (bit_items >= RANDOM_ITEMS - RANDOM_ITEMS / 10)
            begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            else
            begin
                tx_gaps = ($urandom_range(0, 2) != 0);
                rx_gaps = ($urandom_range(0, 2) != 0);
            end
            method = ($urandom_range(0, 24) == 0) ? 2'($urandom_range(2, 3))
                                                  : 2'($urandom_range(0, 1));
            flat = ($urandom_range(0, 19) == 0);
            if (flat)
            begin
                // Large blocks only as cheap zero-width escape runs
                bs     = $urandom_range(4096, 131071);
                porder = $urandom_range(0, 3);
                po     = $urandom_range(0, 32);
            end
            else
            begin
                bs     = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 64)
                                                     : $urandom_range(1, 24);
                porder = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5)
                                                     : $urandom_range(0, 2);
                part   = bs >> porder;
                if (part > 32)
                    part = 32;
                case ($urandom_range(0, 7))
                    0:       po = $urandom_range(0, 32);
                    1:       po = part;
                    default: po = $urandom_range(0, part);
                endcase
            end
            start_section(17'(bs), 6'(po));
            build_section(bs, po, method, porder, flat);
            // Break some sections: cut short or corrupt one bit
            if (bit_stream.size() != 0 && $urandom_range(0, 5) == 0)
            begin
                idx = $urandom_range(0, bit_stream.size() - 1);
                while (bit_stream.size() > idx)
                    void'(bit_stream.pop_back());
            end
            else if (bit_stream.size() != 0 && $urandom_range(0, 9) == 0)
            begin
                idx = $urandom_range(0, bit_stream.size() - 1);
                bit_stream[idx] = ~bit_stream[idx];
            end
            repeat ($urandom_range(0, 2)) bit_stream.push_back(1'($urandom_range(0, 1)));
            send_stream();
        end
    endtask

    initial
    begin
        reset_decoder();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_header_errors();
        test_empty_partitions();
        test_rice_extremes();
        test_random_sections();
        wait_for_results();
        repeat (16) @(posedge clk);
        if (pending_residuals.size() != 0)
        begin
            if (fail_count < 10)
                $display("%0d expected results never arrived", pending_residuals.size());
            fail_count += pending_residuals.size();
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== flac_residual_rice_decoder_core.f =====
sv/frrd_pkg.sv
sv/flac_residual_rice_decoder_core.sv
bench/tb_flac_residual_rice_decoder_core.sv
